>>> rtl/iprb_pkg.sv
// ----------------------------------------------------------------------------
// iprb_pkg
// Shared types and constants of the I/O port range bitmap unit.
// ----------------------------------------------------------------------------
`default_nettype none

package iprb_pkg;

  // Bitmap geometry: MapWords words of 32 ports each.
  localparam int unsigned MapWords   = 32;
  localparam int unsigned TotalPorts = MapWords * 32;
  localparam int unsigned WordW      = (MapWords > 1) ? $clog2(MapWords) : 1;
  // start + count from two 16-bit fields
  localparam int unsigned EndW       = 17;
  localparam int unsigned QueueDepth = 2;

  // Request kinds on the input tuser
  localparam logic [1:0] REQ_RESERVE = 2'd0;
  localparam logic [1:0] REQ_CHECK   = 2'd1;
  localparam logic [1:0] REQ_PERMIT  = 2'd2;

  // Result status codes
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_RANGE = 2'd1;
  localparam logic [1:0] STS_PERM  = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_RESERVE,
    OP_CHECK,
    OP_PERMIT
  } op_e;

  // Classified command handed from the front to the back
  typedef struct packed {
    op_e              op;
    logic             value;       // permit: new denied bit value
    logic [WordW-1:0] first_word;
    logic [WordW-1:0] last_word;
    logic [4:0]       lo_bit;      // first bit in first word
    logic [4:0]       hi_bit;      // last bit in last word, inclusive
    logic [1:0]       status;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/iprb_front.sv
// ----------------------------------------------------------------------------
// iprb_front
// Accepts requests, clips and validates the range, builds a word command.
// ----------------------------------------------------------------------------
`default_nettype none

module iprb_front (
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [39:0]   s_axis_tdata,  // start_port[15:0], port_count[31:16],
                                            // turn_on[32], is_privileged[33], zero pad
  input  wire logic [1:0]    s_axis_tuser,  // req_type
  input  wire logic          q_full_i,
  output logic               q_push_o,
  output iprb_pkg::cmd_t     q_data_o
);

  logic [15:0]                 start_port;
  logic [15:0]                 port_count;
  logic                        turn_on;
  logic                        is_privileged;
  logic [iprb_pkg::EndW-1:0]   start_x;
  logic [iprb_pkg::EndW-1:0]   end_x;
  logic [iprb_pkg::EndW-1:0]   total_x;
  logic [iprb_pkg::EndW-1:0]   hi_x;
  logic [iprb_pkg::EndW-1:0]   hi_last;

  assign start_port    = s_axis_tdata[15:0];
  assign port_count    = s_axis_tdata[31:16];
  assign turn_on       = s_axis_tdata[32];
  assign is_privileged = s_axis_tdata[33];

  assign start_x = {1'b0, start_port};
  assign end_x   = {1'b0, start_port} + {1'b0, port_count};
  assign total_x = iprb_pkg::EndW'(iprb_pkg::TotalPorts);
  assign hi_x    = (end_x > total_x) ? total_x : end_x;
  assign hi_last = hi_x - 1'b1;

  assign s_axis_tready = !q_full_i;
  assign q_push_o      = s_axis_tvalid && !q_full_i;

  always_comb begin
    q_data_o            = '0;
    q_data_o.op         = iprb_pkg::OP_NONE;
    q_data_o.first_word = start_x[iprb_pkg::WordW+4:5];
    q_data_o.last_word  = hi_last[iprb_pkg::WordW+4:5];
    q_data_o.lo_bit     = start_port[4:0];
    q_data_o.hi_bit     = hi_last[4:0];
    q_data_o.value      = !turn_on;
    q_data_o.status     = iprb_pkg::STS_OK;
    case (s_axis_tuser)
      iprb_pkg::REQ_RESERVE, iprb_pkg::REQ_CHECK: begin
        // start past the end or empty clipped range: nothing to walk
        if (start_x <= total_x && hi_x > start_x) begin
          q_data_o.op = (s_axis_tuser == iprb_pkg::REQ_RESERVE) ?
                        iprb_pkg::OP_RESERVE : iprb_pkg::OP_CHECK;
        end
      end
      iprb_pkg::REQ_PERMIT: begin
        if (port_count == 16'd0 || end_x > total_x) begin
          q_data_o.status = iprb_pkg::STS_RANGE;
        end else if (!is_privileged) begin
          q_data_o.status = iprb_pkg::STS_PERM;
        end else begin
          q_data_o.op = iprb_pkg::OP_PERMIT;
        end
      end
      default: begin
        q_data_o.status = iprb_pkg::STS_RANGE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/iprb_queue.sv
// ----------------------------------------------------------------------------
// iprb_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module iprb_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire iprb_pkg::cmd_t  push_data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output iprb_pkg::cmd_t       pop_data_o
);

  localparam int unsigned PtrW = (iprb_pkg::QueueDepth > 1) ?
                                 $clog2(iprb_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(iprb_pkg::QueueDepth + 1);

  iprb_pkg::cmd_t entry_q [iprb_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o     = (count_q == CntW'(iprb_pkg::QueueDepth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = entry_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(iprb_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(iprb_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/iprb_back.sv
// ----------------------------------------------------------------------------
// iprb_back
// Holds both bitmaps and walks a command one word per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module iprb_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cmd_valid_i,
  input  wire iprb_pkg::cmd_t  cmd_i,
  output logic                 cmd_pop_o,
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  output logic [7:0]           m_axis_tdata   // status[1:0], region_busy[2], zero pad
);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_WALK
  } state_e;

  state_e                    state_q;
  iprb_pkg::cmd_t            cmd_q;
  logic [iprb_pkg::WordW-1:0] word_q;
  logic                      busy_q;
  logic                      res_valid_q;
  logic [1:0]                res_status_q;
  logic                      res_busy_q;

  logic [31:0] reserved_q [iprb_pkg::MapWords];
  logic [31:0] denied_q   [iprb_pkg::MapWords];

  logic [4:0]  lo_eff;
  logic [4:0]  hi_eff;
  logic [31:0] mask;
  logic [31:0] res_word;
  logic [31:0] den_word;
  logic        hit;
  logic        at_last;

  assign lo_eff   = (word_q == cmd_q.first_word) ? cmd_q.lo_bit : 5'd0;
  assign hi_eff   = (word_q == cmd_q.last_word) ? cmd_q.hi_bit : 5'd31;
  assign mask     = ({32{1'b1}} << lo_eff) & ({32{1'b1}} >> (5'd31 - hi_eff));
  assign res_word = reserved_q[word_q];
  assign den_word = denied_q[word_q];
  assign hit      = |(res_word & mask);
  assign at_last  = (word_q == cmd_q.last_word);

  assign cmd_pop_o     = (state_q == ST_IDLE) && cmd_valid_i && !res_valid_q;
  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = {5'd0, res_busy_q, res_status_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
      busy_q      <= 1'b0;
      for (int i = 0; i < int'(iprb_pkg::MapWords); i++) begin
        reserved_q[i] <= '0;
        denied_q[i]   <= '1;
      end
    end else begin
      if (res_valid_q && m_axis_tready) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_pop_o) begin
            if (cmd_i.op == iprb_pkg::OP_NONE) begin
              res_valid_q <= 1'b1;
            end else begin
              state_q <= ST_WALK;
            end
            busy_q <= 1'b0;
          end
        end
        ST_WALK: begin
          case (cmd_q.op)
            iprb_pkg::OP_RESERVE: reserved_q[word_q] <= res_word | mask;
            iprb_pkg::OP_PERMIT: begin
              denied_q[word_q] <= cmd_q.value ? (den_word | mask) : (den_word & ~mask);
            end
            default: ;
          endcase
          if (hit && cmd_q.op == iprb_pkg::OP_CHECK) begin
            busy_q <= 1'b1;
          end
          if (at_last) begin
            state_q     <= ST_IDLE;
            res_valid_q <= 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Command and result payload
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (cmd_pop_o) begin
          cmd_q        <= cmd_i;
          word_q       <= cmd_i.first_word;
          res_status_q <= cmd_i.status;
          res_busy_q   <= 1'b0;
        end
      end
      ST_WALK: begin
        word_q <= word_q + 1'b1;
        if (at_last) begin
          res_busy_q <= busy_q || (hit && cmd_q.op == iprb_pkg::OP_CHECK);
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/io_port_range_bitmap_unit.sv
// ----------------------------------------------------------------------------
// io_port_range_bitmap_unit
// Port reservation and permission bitmaps with range reserve, check, permit.
// ----------------------------------------------------------------------------
// A request (tuser: 0 reserve, 1 check, 2 permit) is validated and clipped in
// the front, queued (two entries), then walked by the back over the bitmap
// words it covers, one 32-port word per cycle. The back takes the command,
// walks its words, and holds its result until it transfers before the next
// command is taken; rejected or empty requests skip the walk. The single-word
// read-modify-write of the bitmaps sets the walk rate. One result per request;
// input is taken while a result waits on the output, until the queue is full.
`default_nettype none

module io_port_range_bitmap_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // start_port[15:0], port_count[31:16],
                                           // turn_on[32], is_privileged[33], zero pad
  input  wire logic [1:0]  s_axis_tuser,   // req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata    // status[1:0], region_busy[2], zero pad
);

  logic           q_full;
  logic           q_push;
  logic           q_valid;
  logic           q_pop;
  iprb_pkg::cmd_t q_wdata;
  iprb_pkg::cmd_t q_rdata;

  iprb_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_data_o      (q_wdata)
  );

  iprb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_rdata)
  );

  iprb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (q_valid),
    .cmd_i         (q_rdata),
    .cmd_pop_o     (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Reserve, check and permit requests against io_port_range_bitmap_unit.
// A table of directed requests (range extremes, clipping, rejects) runs first.
// Random traffic follows, with bursty gaps on the input and output streams.
// Every response is compared with the table's expected value or with a local model of the two port bitmaps.
// ----------------------------------------------------------------------------

module testbench;

  // Request kind the block does not define; must come back as a range error
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int unsigned RandomItems = 2000;
  localparam int unsigned QuietItems  = 200;   // tail with no idling at all
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned DrainCycles   = 60;
  localparam int unsigned DirRows       = 25;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] start;
    logic [15:0] count;
    logic        turn_on;
    logic        privileged;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       busy;
  } result_t;

  typedef struct packed {
    req_t    req;
    logic    typed;      // 1: the expected response below is used as is
    result_t want;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // start_port[15:0], port_count[31:16],
                               // turn_on[32], is_privileged[33], zero pad
  logic [1:0]  s_axis_tuser;   // req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // status[1:0], region_busy[2], zero pad

  io_port_range_bitmap_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  logic [31:0] reserved_words [iprb_pkg::MapWords];
  logic [31:0] denied_words   [iprb_pkg::MapWords];
  result_t     pending_results [$];
  dir_row_t    dir_rows [DirRows];
  int unsigned mismatches;
  int unsigned responses;
  int unsigned gap_pct;
  bit          running;

  always #2 clk_i = ~clk_i;

  // Applies one request to the local bitmaps and returns its response
  function automatic result_t predict_request(req_t r);
    result_t     res;
    int unsigned lo;
    int unsigned hi;
    res = '0;
    lo  = 32'(r.start);
    hi  = lo + 32'(r.count);
    case (r.kind)
      iprb_pkg::REQ_RESERVE, iprb_pkg::REQ_CHECK: begin
        // start == TotalPorts is legal and yields an empty range
        if (lo <= iprb_pkg::TotalPorts) begin
          if (hi > iprb_pkg::TotalPorts) hi = iprb_pkg::TotalPorts;
          for (int unsigned p = lo; p < hi; p++) begin
            if (r.kind == iprb_pkg::REQ_RESERVE) reserved_words[p / 32][p % 32] = 1'b1;
            else if (reserved_words[p / 32][p % 32]) res.busy = 1'b1;
          end
        end
      end
      iprb_pkg::REQ_PERMIT: begin
        // range checks win over the privilege check
        if (r.count == 0 || hi > iprb_pkg::TotalPorts) res.status = iprb_pkg::STS_RANGE;
        else if (!r.privileged) res.status = iprb_pkg::STS_PERM;
        else begin
          for (int unsigned p = lo; p < hi; p++) denied_words[p / 32][p % 32] = !r.turn_on;
        end
      end
      default: res.status = iprb_pkg::STS_RANGE;
    endcase
    return res;
  endfunction

  function automatic req_t random_request();
    req_t        r;
    int unsigned pick;
    pick         = $urandom_range(0, 99);
    r.turn_on    = 1'($urandom_range(0, 1));
    r.privileged = ($urandom_range(0, 3) != 0);
    r.start      = 16'($urandom_range(0, iprb_pkg::TotalPorts - 1));
    r.count      = 16'($urandom_range(1, 8));
    if (pick < 8) begin
      // keep reservations short so checks do not saturate
      r.kind  = iprb_pkg::REQ_RESERVE;
      r.count = 16'($urandom_range(0, 3));
    end else if (pick < 11) begin
      r.kind  = iprb_pkg::REQ_RESERVE;
      r.start = 16'($urandom_range(iprb_pkg::TotalPorts + 1, 65535));
      r.count = 16'($urandom_range(0, 65535));
    end else if (pick < 50) begin
      r.kind  = iprb_pkg::REQ_CHECK;
      r.start = 16'($urandom_range(0, iprb_pkg::TotalPorts + 8));
      if ($urandom_range(0, 9) == 0) r.count = 16'($urandom_range(0, 65535));
      else r.count = 16'($urandom_range(0, 12));
    end else if (pick < 92) begin
      r.kind = iprb_pkg::REQ_PERMIT;
      if ($urandom_range(0, 9) == 0) r.count = 16'($urandom_range(0, 65535));
      else r.count = 16'($urandom_range(0, iprb_pkg::TotalPorts - 32'(r.start) + 2));
    end else begin
      r.kind  = 2'($urandom_range(0, 3));
      r.start = 16'($urandom_range(0, 65535));
      r.count = 16'($urandom_range(0, 65535));
    end
    return r;
  endfunction

  // Drives one request, waits for its transfer, then records the response due
  task automatic send_request(req_t r, logic typed, result_t want);
    result_t res;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.kind;
    s_axis_tdata  <= {6'b0, r.privileged, r.turn_on, r.count, r.start};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    res = predict_request(r);
    pending_results.push_back(typed ? want : res);
  endtask

  // Output side: compare, then decide tready for the next cycle
  always @(posedge clk_i) begin : result_side
    result_t     got;
    result_t     want;
    int unsigned stall_left;
    if (running) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tdata[1:0];
        got.busy   = m_axis_tdata[2];
        responses++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("response %0d: unexpected transfer, status %0d busy %0d",
                     responses, got.status, got.busy);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status || got.busy !== want.busy) begin
            mismatches++;
            if (mismatches <= 10)
              $display("response %0d: expected status %0d busy %0d, got status %0d busy %0d",
                       responses, want.status, want.busy, got.status, got.busy);
          end
        end
      end
      if (stall_left == 0 && gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        stall_left = $urandom_range(1, 9);
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    int unsigned quiet_cycles;
    if (running) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles == WatchdogLimit) begin
        $display("[io_port_range_bitmap_unit] ERROR");
        $finish;
      end
    end
  end

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = iprb_pkg::REQ_RESERVE;
    m_axis_tready = 1'b0;
    mismatches    = 0;
    responses     = 0;
    gap_pct       = 20;
    running       = 1'b0;
    for (int i = 0; i < iprb_pkg::MapWords; i++) begin
      reserved_words[i] = '0;
      denied_words[i]   = '1;
    end

    //   kind                   start      count      on    priv  typed  status  busy
    dir_rows = '{
      '{'{iprb_pkg::REQ_CHECK,   16'd0,     16'd1024,  1'b0, 1'b0}, 1'b1,
        '{iprb_pkg::STS_OK,    1'b0}},
      '{'{iprb_pkg::REQ_CHECK,   16'd1024,  16'd65535, 1'b0, 1'b0}, 1'b1,
        '{iprb_pkg::STS_OK,    1'b0}},
      '{'{iprb_pkg::REQ_CHECK,   16'd65535, 16'd65535, 1'b1, 1'b1}, 1'b1,
        '{iprb_pkg::STS_OK,    1'b0}},
      '{'{iprb_pkg::REQ_RESERVE, 16'd1025,  16'd65535, 1'b0, 1'b1}, 1'b1,
        '{iprb_pkg::STS_OK,    1'b0}},
      '{'{iprb_pkg::REQ_RESERVE, 16'd0,     16'd0,     1'b0, 1'b0}, 1'b1,
        '{iprb_pkg::STS_OK,    1'b0}},
      '{'{iprb_pkg::REQ_CHECK,   16'd0,     16'd0,     1'b0, 1'b0}, 1'b1,
        '{iprb_pkg::STS_OK,    1'b0}},
      '{'{iprb_pkg::REQ_CHECK,   16'd0,     16'd1024,  1'b0, 1'b0}, 1'b1,
        '{iprb_pkg::STS_OK,    1'b0}},
      // top port only, count clipped at the end of the map
      '{'{iprb_pkg::REQ_RESERVE, 16'd1023,  16'd65535, 1'b1, 1'b0}, 1'b1,
        '{iprb_pkg::STS_OK,    1'b0}},
      '{'{iprb_pkg::REQ_CHECK,   16'd1023,  16'd1,     1'b0, 1'b0}, 1'b1,
        '{iprb_pkg::STS_OK,    1'b1}},
      '{'{iprb_pkg::REQ_CHECK,   16'd0,     16'd1023,  1'b0, 1'b0}, 1'b1,
        '{iprb_pkg::STS_OK,    1'b0}},
      '{'{iprb_pkg::REQ_CHECK,   16'd1000,  16'd65535, 1'b0, 1'b0}, 1'b1,
        '{iprb_pkg::STS_OK,    1'b1}},
      // straddles the first word boundary
      '{'{iprb_pkg::REQ_RESERVE, 16'd31,    16'd2,     1'b0, 1'b0}, 1'b1,
        '{iprb_pkg::STS_OK,    1'b0}},
      '{'{iprb_pkg::REQ_CHECK,   16'd32,    16'd1,     1'b0, 1'b0}, 1'b1,
        '{iprb_pkg::STS_OK,    1'b1}},
      '{'{iprb_pkg::REQ_CHECK,   16'd30,    16'd1,     1'b0, 1'b0}, 1'b1,
        '{iprb_pkg::STS_OK,    1'b0}},
      '{'{iprb_pkg::REQ_CHECK,   16'd0,     16'd40,    1'b0, 1'b0}, 1'b0,
        '{iprb_pkg::STS_OK,    1'b0}},
      '{'{iprb_pkg::REQ_PERMIT,  16'd0,     16'd0,     1'b1, 1'b1}, 1'b1,
        '{iprb_pkg::STS_RANGE, 1'b0}},
      '{'{iprb_pkg::REQ_PERMIT,  16'd65535, 16'd65535, 1'b1, 1'b1}, 1'b1,
        '{iprb_pkg::STS_RANGE, 1'b0}},
      '{'{iprb_pkg::REQ_PERMIT,  16'd1000,  16'd25,    1'b1, 1'b1}, 1'b1,
        '{iprb_pkg::STS_RANGE, 1'b0}},
      '{'{iprb_pkg::REQ_PERMIT,  16'd5,     16'd0,     1'b1, 1'b0}, 1'b1,
        '{iprb_pkg::STS_RANGE, 1'b0}},
      '{'{iprb_pkg::REQ_PERMIT,  16'd1000,  16'd24,    1'b1, 1'b0}, 1'b1,
        '{iprb_pkg::STS_PERM,  1'b0}},
      '{'{iprb_pkg::REQ_PERMIT,  16'd0,     16'd1024,  1'b1, 1'b1}, 1'b1,
        '{iprb_pkg::STS_OK,    1'b0}},
      '{'{iprb_pkg::REQ_PERMIT,  16'd0,     16'd1024,  1'b0, 1'b1}, 1'b1,
        '{iprb_pkg::STS_OK,    1'b0}},
      '{'{iprb_pkg::REQ_PERMIT,  16'd100,   16'd37,    1'b1, 1'b1}, 1'b0,
        '{iprb_pkg::STS_OK,    1'b0}},
      '{'{REQ_UNKNOWN,           16'd65535, 16'd65535, 1'b1, 1'b1}, 1'b1,
        '{iprb_pkg::STS_RANGE, 1'b0}},
      '{'{REQ_UNKNOWN,           16'd0,     16'd0,     1'b0, 1'b0}, 1'b1,
        '{iprb_pkg::STS_RANGE, 1'b0}}
    };

    repeat (10) @(posedge clk_i);
    rst_ni  <= 1'b1;
    running <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

    for (int unsigned n = 0; n < RandomItems; n++) begin
      // idle density changes in phases; none in the tail
      if (n >= RandomItems - QuietItems) gap_pct = 0;
      else if (n % 250 == 0) begin
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 15;
          default: gap_pct = 50;
        endcase
      end
      send_request(random_request(), 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[io_port_range_bitmap_unit] OK");
    end else begin
      $display("[io_port_range_bitmap_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/iprb_pkg.sv
rtl/iprb_front.sv
rtl/iprb_queue.sv
rtl/iprb_back.sv
rtl/io_port_range_bitmap_unit.sv
bench/testbench.sv
